// ===== rtl/button_press_classifier_with_power_off_unit_assert.svh =====
// ----------------------------------------------------------------------------
// button press classifier assertion macros
// concurrent checks clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_WITH_POWER_OFF_UNIT_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_WITH_POWER_OFF_UNIT_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types, register map and reset values of the button press classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned HISTORY_LEN_DEF = 12;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_MAX_ON      = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
  localparam logic [2:0] REG_SHORT_MIN   = 3'd2;
  localparam logic [2:0] REG_SHORT_MAX   = 3'd3;
  localparam logic [2:0] REG_BLINK_HALF  = 3'd4;

  localparam logic [31:0] MAX_ON_DEF     = 32'd5400000;
  localparam logic [15:0] LONG_PRESS_DEF = 16'd1200;
  localparam logic [15:0] SHORT_MIN_DEF  = 16'd30;
  localparam logic [15:0] SHORT_MAX_DEF  = 16'd350;
  localparam logic [15:0] BLINK_HALF_DEF = 16'd2000;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_ON_TIME = 2'd1;
  localparam logic [1:0] CAUSE_BUTTON  = 2'd2;

  typedef struct packed {
    logic [31:0] max_on_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] short_min_ticks;
    logic [15:0] short_max_ticks;
    logic [15:0] blink_half_period;
  } cfg_t;

  typedef struct packed {
    logic [31:0] elapsed;
    logic [15:0] blink;
    logic [15:0] hold;
    logic        press;
    logic        view;
    logic        led;
    logic        halted;
    logic [1:0]  cause;
  } state_t;

endpackage

// ===== rtl/button_press_classifier_with_power_off_unit.sv =====
// path: a beat accepted goes to the input register, then to the result register
// throughput: one beat per cycle while the result is not stalled
// a stalled result holds the result register; the input register still takes one beat
// reset (rst, synchronous): empties both registers, loads default limits, sets the led, clears other state
// ----------------------------------------------------------------------------
// button_press_classifier_with_power_off_unit
// debounced button classifier with long-press and on-time power cut
// ----------------------------------------------------------------------------
`include "button_press_classifier_with_power_off_unit_assert.svh"

module button_press_classifier_with_power_off_unit #(
  parameter int unsigned HISTORY_LEN = bpc_pkg::HISTORY_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        button_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        power_cut,
  output logic [1:0]                  cut_cause,
  output logic                        press_active,
  output logic [15:0]                 hold_ticks,
  output logic                        view_select,
  output logic                        led_level,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
  output logic [bpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  bpc_pkg::cfg_t           cfg;
  bpc_pkg::state_t         st;
  bpc_pkg::state_t         st_next;
  logic [HISTORY_LEN-1:0]  hist;
  logic [HISTORY_LEN-1:0]  hist_next;
  logic                    s1_valid;
  logic                    s1_level;
  logic                    res_free;
  logic                    res_load;
  logic                    in_take;

  bpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpc_tick #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_tick (
    .cfg       (cfg),
    .st        (st),
    .hist      (hist),
    .level     (s1_level),
    .st_next   (st_next),
    .hist_next (hist_next)
  );

  assign res_free = !out_valid || !out_stall;
  assign res_load = s1_valid && res_free;
  assign in_stall = s1_valid && !res_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (res_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level <= button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.elapsed <= '0;
      st.blink   <= '0;
      st.hold    <= '0;
      st.press   <= 1'b0;
      st.view    <= 1'b0;
      st.led     <= 1'b1;
      st.halted  <= 1'b0;
      st.cause   <= bpc_pkg::CAUSE_NONE;
      hist       <= '0;
    end else if (res_load) begin
      st   <= st_next;
      hist <= hist_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      power_cut    <= st_next.halted;
      cut_cause    <= st_next.halted ? st_next.cause : bpc_pkg::CAUSE_NONE;
      press_active <= st_next.press;
      hold_ticks   <= st_next.hold;
      view_select  <= st_next.view;
      led_level    <= st_next.led;
    end
  end

  `BPC_ASSERT_IMP(a_cause_matches_cut, out_valid, power_cut == (cut_cause != bpc_pkg::CAUSE_NONE), "cut cause disagrees with power cut")
  `BPC_ASSERT_NXT(a_cut_sticky, st.halted, st.halted, "power cut released")
  `BPC_ASSERT_NXT(a_frozen_after_cut, st.halted, $stable(st.elapsed) && $stable(st.hold), "state moved after power cut")
  `BPC_ASSERT_IMP(a_stall_only_when_full, in_stall, s1_valid && out_valid && out_stall, "input stalled with room to advance")

endmodule

// ===== rtl/bpc_cfg.sv =====
// ----------------------------------------------------------------------------
// bpc_cfg
// apb register file holding the classifier limits
// ----------------------------------------------------------------------------
module bpc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpc_pkg::DATA_W-1:0]   pwdata,
  output logic [bpc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output bpc_pkg::cfg_t                cfg
);

  logic [bpc_pkg::ADDR_W-3:0] reg_idx;
  logic                       wr_en;

  assign reg_idx = paddr[bpc_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_on_ticks      <= bpc_pkg::MAX_ON_DEF;
      cfg.long_press_ticks  <= bpc_pkg::LONG_PRESS_DEF;
      cfg.short_min_ticks   <= bpc_pkg::SHORT_MIN_DEF;
      cfg.short_max_ticks   <= bpc_pkg::SHORT_MAX_DEF;
      cfg.blink_half_period <= bpc_pkg::BLINK_HALF_DEF;
    end else if (wr_en) begin
      unique case (reg_idx)
        bpc_pkg::REG_MAX_ON:     cfg.max_on_ticks      <= pwdata;
        bpc_pkg::REG_LONG_PRESS: cfg.long_press_ticks  <= pwdata[15:0];
        bpc_pkg::REG_SHORT_MIN:  cfg.short_min_ticks   <= pwdata[15:0];
        bpc_pkg::REG_SHORT_MAX:  cfg.short_max_ticks   <= pwdata[15:0];
        bpc_pkg::REG_BLINK_HALF: cfg.blink_half_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bpc_pkg::REG_MAX_ON:     prdata = cfg.max_on_ticks;
      bpc_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg.long_press_ticks};
      bpc_pkg::REG_SHORT_MIN:  prdata = {16'd0, cfg.short_min_ticks};
      bpc_pkg::REG_SHORT_MAX:  prdata = {16'd0, cfg.short_max_ticks};
      bpc_pkg::REG_BLINK_HALF: prdata = {16'd0, cfg.blink_half_period};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== rtl/bpc_tick.sv =====
// ----------------------------------------------------------------------------
// bpc_tick
// next-state logic for one tick: window classify, hold count, view toggle, cuts, led
// ----------------------------------------------------------------------------
module bpc_tick #(
  parameter int unsigned HISTORY_LEN = bpc_pkg::HISTORY_LEN_DEF
) (
  input  bpc_pkg::cfg_t           cfg,
  input  bpc_pkg::state_t         st,
  input  logic [HISTORY_LEN-1:0]  hist,
  input  logic                    level,
  output bpc_pkg::state_t         st_next,
  output logic [HISTORY_LEN-1:0]  hist_next
);

  localparam logic [HISTORY_LEN-1:0] HIST_ALL = '1;
  localparam logic [HISTORY_LEN-1:0] HIST_TOP = {1'b1, {(HISTORY_LEN-1){1'b0}}};

  always_comb begin
    st_next   = st;
    hist_next = hist;
    if (!st.halted) begin
      st_next.elapsed = st.elapsed + 32'd1;
      st_next.blink   = st.blink + 16'd1;
      if (st_next.elapsed == cfg.max_on_ticks) begin
        st_next.halted = 1'b1;
        st_next.cause  = bpc_pkg::CAUSE_ON_TIME;
      end else begin
        hist_next = {hist[HISTORY_LEN-2:0], level};
        if (hist_next == HIST_ALL) begin
          st_next.press = 1'b0;
        end else if (hist_next == HIST_TOP) begin
          st_next.hold  = '0;
          st_next.press = 1'b1;
        end else if (hist_next == '0 && st.hold != bpc_pkg::HOLD_MAX) begin
          st_next.hold = st.hold + 16'd1;
        end
        if (st_next.hold >= cfg.long_press_ticks) begin
          st_next.hold   = '0;
          st_next.halted = 1'b1;
          st_next.cause  = bpc_pkg::CAUSE_BUTTON;
        end else begin
          if (st_next.hold > cfg.short_min_ticks && st_next.hold <= cfg.short_max_ticks
              && !st_next.press) begin
            st_next.hold = '0;
            st_next.view = ~st.view;
          end
          if (st_next.blink == cfg.blink_half_period) begin
            st_next.blink = '0;
            st_next.led   = ~st.led;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the button press classifier: a table of directed
// ticks and register writes, then random press/release sequences mixed with
// noise under several limit settings, ending in a sticky power cut. every
// result beat is checked against the table's expected value or a cycle-free
// model of the tick logic, with random input gaps and random result stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import bpc_pkg::*;

  localparam int unsigned HIST_LEN = HISTORY_LEN_DEF;
  localparam logic [HIST_LEN-1:0] HIST_ALL_HIGH = '1;
  localparam logic [HIST_LEN-1:0] HIST_EDGE = {1'b1, {(HIST_LEN-1){1'b0}}};
  localparam logic [2:0] REG_FIRST_SPARE = REG_BLINK_HALF + 3'd1;
  localparam logic [2:0] REG_LAST_SPARE = '1;
  localparam int unsigned LOW_RUN_MAX = 40;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_TICKS = 110;
  localparam int unsigned FINAL_TICKS = 150;

  typedef struct packed {
    logic        power_cut;
    logic [1:0]  cut_cause;
    logic        press_active;
    logic [15:0] hold_ticks;
    logic        view_select;
    logic        led_level;
  } tick_result_t;

  typedef struct packed {
    logic [31:0]         elapsed;
    logic [15:0]         blink;
    logic [HIST_LEN-1:0] hist;
    logic [15:0]         hold;
    logic                press;
    logic                view;
    logic                led;
    logic                halted;
    logic [1:0]          cause;
  } button_state_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic         level;
    logic [2:0]   idx;
    logic [31:0]  value;
    logic         typed;
    tick_result_t exp;
  } plan_row_t;

  localparam tick_result_t NO_RES = '0;
  localparam plan_row_t TICK_LO = '{ROW_TICK, 1'b0, REG_MAX_ON, 32'd0, 1'b0, NO_RES};
  localparam plan_row_t TICK_HI = '{ROW_TICK, 1'b1, REG_MAX_ON, 32'd0, 1'b0, NO_RES};

  // reset window is all low, so the hold count starts climbing at once
  localparam plan_row_t PLAN [30] = '{
    '{ROW_TICK, 1'b0, REG_MAX_ON, 32'd0, 1'b1, '{1'b0, CAUSE_NONE, 1'b0, 16'd1, 1'b0, 1'b1}},
    '{ROW_TICK, 1'b0, REG_MAX_ON, 32'd0, 1'b1, '{1'b0, CAUSE_NONE, 1'b0, 16'd2, 1'b0, 1'b1}},
    TICK_HI,
    TICK_LO, TICK_LO, TICK_LO, TICK_LO, TICK_LO, TICK_LO,
    TICK_LO, TICK_LO, TICK_LO, TICK_LO, TICK_LO,
    TICK_LO,
    '{ROW_WRITE, 1'b0, REG_SHORT_MIN, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, 1'b0, REG_SHORT_MAX, 32'd65535, 1'b0, NO_RES},
    '{ROW_WRITE, 1'b0, REG_FIRST_SPARE, 32'hFFFF_FFFF, 1'b0, NO_RES},
    TICK_HI, TICK_HI, TICK_HI, TICK_HI, TICK_HI, TICK_HI,
    TICK_HI, TICK_HI, TICK_HI, TICK_HI, TICK_HI, TICK_HI
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                button_level = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                power_cut;
  logic [1:0]          cut_cause;
  logic                press_active;
  logic [15:0]         hold_ticks;
  logic                view_select;
  logic                led_level;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cfg_t          lim;
  button_state_t btn;
  tick_result_t  pending_results [$];
  int            fail_count = 0;
  int            results_seen = 0;
  int            stall_ref = 0;
  int            stall_left = 0;
  int            ticks_sent = 0;
  int            settings_used = 0;
  int            view_flips = 0;
  bit            tx_idle = 1'b0;
  bit            rx_idle = 1'b0;

  button_press_classifier_with_power_off_unit #(
    .HISTORY_LEN(HIST_LEN)
  ) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .button_level(button_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .power_cut(power_cut), .cut_cause(cut_cause), .press_active(press_active),
    .hold_ticks(hold_ticks), .view_select(view_select), .led_level(led_level),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic string show(input tick_result_t r);
    return $sformatf("cut=%0d cause=%0d press=%0d hold=%0d view=%0d led=%0d",
                     r.power_cut, r.cut_cause, r.press_active, r.hold_ticks,
                     r.view_select, r.led_level);
  endfunction

  function automatic void reset_model();
    lim.max_on_ticks = MAX_ON_DEF;
    lim.long_press_ticks = LONG_PRESS_DEF;
    lim.short_min_ticks = SHORT_MIN_DEF;
    lim.short_max_ticks = SHORT_MAX_DEF;
    lim.blink_half_period = BLINK_HALF_DEF;
    btn = '0;
    btn.led = 1'b1;
  endfunction

  function automatic logic [31:0] limit_value(input logic [2:0] idx);
    case (idx)
      REG_MAX_ON:     return lim.max_on_ticks;
      REG_LONG_PRESS: return {16'd0, lim.long_press_ticks};
      REG_SHORT_MIN:  return {16'd0, lim.short_min_ticks};
      REG_SHORT_MAX:  return {16'd0, lim.short_max_ticks};
      REG_BLINK_HALF: return {16'd0, lim.blink_half_period};
      default:        return '0;
    endcase
  endfunction

  // one millisecond tick of the classifier, returns the state after it
  function automatic tick_result_t classify_tick(input logic lvl);
    tick_result_t r;
    if (!btn.halted) begin
      btn.elapsed = btn.elapsed + 32'd1;
      btn.blink = btn.blink + 16'd1;
      if (btn.elapsed == lim.max_on_ticks) begin
        btn.halted = 1'b1;
        btn.cause = CAUSE_ON_TIME;
      end else begin
        btn.hist = {btn.hist[HIST_LEN-2:0], lvl};
        if (btn.hist == HIST_ALL_HIGH) btn.press = 1'b0;
        if (btn.hist == HIST_EDGE) begin
          btn.hold = '0;
          btn.press = 1'b1;
        end
        if (btn.hist == '0 && btn.hold != HOLD_MAX) btn.hold = btn.hold + 16'd1;
        if (btn.hold >= lim.long_press_ticks) begin
          btn.hold = '0;
          btn.halted = 1'b1;
          btn.cause = CAUSE_BUTTON;
        end else begin
          if (btn.hold > lim.short_min_ticks && btn.hold <= lim.short_max_ticks &&
              !btn.press) begin
            btn.hold = '0;
            btn.view = ~btn.view;
            view_flips++;
          end
          if (btn.blink == lim.blink_half_period) begin
            btn.blink = '0;
            btn.led = ~btn.led;
          end
        end
      end
    end
    r.power_cut = btn.halted;
    r.cut_cause = btn.halted ? btn.cause : CAUSE_NONE;
    r.press_active = btn.press;
    r.hold_ticks = btn.hold;
    r.view_select = btn.view;
    r.led_level = btn.led;
    return r;
  endfunction

  task automatic drive_tick(input logic lvl, input logic typed, input tick_result_t typed_res);
    int gap;
    tick_result_t res;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    button_level <= lvl;
    do @(posedge clk); while (in_stall);
    res = classify_tick(lvl);
    pending_results.push_back(typed ? typed_res : res);
    ticks_sent++;
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] val,
                            output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_limit(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    settle_idle();
    apb_access(1'b1, idx, val, unused);
    case (idx)
      REG_MAX_ON:     lim.max_on_ticks = val;
      REG_LONG_PRESS: lim.long_press_ticks = val[15:0];
      REG_SHORT_MIN:  lim.short_min_ticks = val[15:0];
      REG_SHORT_MAX:  lim.short_max_ticks = val[15:0];
      REG_BLINK_HALF: lim.blink_half_period = val[15:0];
      default: ;
    endcase
  endtask

  task automatic check_limits();
    logic [31:0] rd;
    settings_used++;
    for (int r = REG_MAX_ON; r <= REG_BLINK_HALF; r++) begin
      apb_access(1'b0, r[2:0], '0, rd);
      if (rd !== limit_value(r[2:0]))
        note_failure($sformatf("register %0d reads %0h, expected %0h",
                               r, rd, limit_value(r[2:0])));
    end
  endtask

  // mostly press/release sequences, some random noise bursts
  task automatic run_phase(input int quota, input int low_max);
    int sent;
    int n_hi;
    int n_lo;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 7) == 0) settle_idle();
      if ($urandom_range(0, 99) < 85) begin
        n_hi = $urandom_range(1, 16);
        n_lo = $urandom_range(1, low_max);
        for (int i = 0; i < n_hi && sent < quota; i++) begin
          drive_tick(1'b1, 1'b0, NO_RES);
          sent++;
        end
        for (int i = 0; i < n_lo && sent < quota; i++) begin
          drive_tick(1'b0, 1'b0, NO_RES);
          sent++;
        end
      end else begin
        n_hi = $urandom_range(1, 8);
        for (int i = 0; i < n_hi && sent < quota; i++) begin
          drive_tick(1'($urandom_range(0, 1)), 1'b0, NO_RES);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch_results
    tick_result_t got;
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {power_cut, cut_cause, press_active, hold_ticks, view_select, led_level};
      results_seen++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result beat: %s", show(got)));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_failure($sformatf("result %0d mismatch: expected %s, got %s",
                                 results_seen, show(want), show(got)));
      end
    end
  end

  // result side backpressure, a fresh stall length after every beat
  always @(negedge clk) begin
    if (results_seen != stall_ref) begin
      stall_ref = results_seen;
      stall_left = rx_idle ? $urandom_range(0, 9) : 0;
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0 && out_valid) stall_left--;
  end

  initial begin : stimulus
    logic [31:0] v;
    bit cut_by_button;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE) write_limit(PLAN[i].idx, PLAN[i].value);
      else drive_tick(PLAN[i].level, PLAN[i].typed, PLAN[i].exp);
    end
    settle_idle();
    check_limits();

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_idle = (ph % 4) != 3;
      rx_idle = (ph % 3) != 2;
      case (ph)
        1:       v = 32'd1;
        2:       v = 32'hFFFF_FFFF;
        default: v = btn.elapsed + 32'd100000 + $urandom_range(0, 1 << 20);
      endcase
      write_limit(REG_MAX_ON, v);
      write_limit(REG_LONG_PRESS, (ph == 3) ? 32'd65535 : $urandom_range(200, 65535));
      case (ph)
        4: begin
          write_limit(REG_SHORT_MIN, 32'd0);
          write_limit(REG_SHORT_MAX, 32'd65535);
        end
        5: begin
          write_limit(REG_SHORT_MIN, 32'd65535);
          write_limit(REG_SHORT_MAX, 32'd0);
        end
        default: begin
          v = $urandom_range(0, 12);
          write_limit(REG_SHORT_MIN, v);
          write_limit(REG_SHORT_MAX, v + $urandom_range(0, 30));
        end
      endcase
      case (ph)
        2:       write_limit(REG_BLINK_HALF, 32'd65535);
        6:       write_limit(REG_BLINK_HALF, 32'd1);
        default: write_limit(REG_BLINK_HALF, $urandom_range(1, 40));
      endcase
      for (int r = REG_FIRST_SPARE; r <= REG_LAST_SPARE; r++)
        write_limit(r[2:0], $urandom());
      check_limits();
      run_phase(PHASE_TICKS, LOW_RUN_MAX);
    end

    // last setting ends in a sticky cut, the ticks after it must change nothing
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    cut_by_button = 1'($urandom_range(0, 1));
    if (cut_by_button)
      write_limit(REG_LONG_PRESS, $urandom_range(0, 1) ? 32'd1 : $urandom_range(2, 30));
    else
      write_limit(REG_MAX_ON, btn.elapsed + $urandom_range(30, 120));
    check_limits();
    run_phase(FINAL_TICKS, cut_by_button ? 70 : LOW_RUN_MAX);

    settle_idle();
    repeat (20) @(posedge clk);
    $display("%0d ticks over %0d limit settings, %0d result beats checked",
             ticks_sent, settings_used, results_seen);
    $display("%0d short presses, power cut %0d with cause %0d",
             view_flips, btn.halted, btn.cause);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
